FILE: rtl/khmma_pkg.sv
// Package for the keyed windowed min/max/average aggregator.
// Holds table geometry, status codes, register indexes and shared types.
// No dependencies.
`default_nettype none
package khmma_pkg;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [16:0] WindowReset = 17'd3600;
  localparam logic [31:0] TtlReset    = 32'd172800;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadType = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  localparam logic [1:0] TypeReal = 2'd0;
  localparam logic [1:0] TypeUns  = 2'd1;

  localparam logic RegWindow = 1'b0;
  localparam logic RegTtl    = 1'b1;

  typedef struct packed {
    logic [63:0] item;
    logic [63:0] host;
    logic        kind;
    logic [31:0] win;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [63:0] sum;
    logic [31:0] cnt;
  } slot_t;

  // division unit handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

FILE: rtl/khmma_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 32 bits unsigned.
// Depends on khmma_pkg.
`default_nettype none
module khmma_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  khmma_pkg::div_req_t      req_i,
  output logic                     done_o,
  output logic [63:0]              quot_o
);
  import khmma_pkg::*;

  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    shifted = {rem_q[31:0], quot_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (!trial[32]) begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

FILE: rtl/keyed_hourly_min_max_avg.sv
// Top level of the keyed windowed min/max/average aggregator.
// Depends on khmma_pkg and khmma_div.
//
// A sample of a valid type takes a bit-serial window-start computation, a
// table scan of one entry per cycle, a divide when a record is exported,
// and, at the first sample of a new window, a second one-entry-per-cycle
// sweep of the table; both scans are paced by the single table read port.
// busy is high for the whole time; the result appears with done_o for one
// cycle and the receiver cannot stall it. No clearing pass after reset.
`default_nettype none
module keyed_hourly_min_max_avg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] item_id_i,
  input  wire logic [63:0] host_id_i,
  input  wire logic [1:0]  sample_type_i,
  input  wire logic        value_present_i,
  input  wire logic [63:0] sample_value_i,
  input  wire logic [31:0] timestamp_seconds_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             export_valid_o,
  output logic [63:0]      export_item_id_o,
  output logic [63:0]      export_host_id_o,
  output logic             export_type_o,
  output logic [31:0]      export_window_start_o,
  output logic [63:0]      export_min_o,
  output logic [63:0]      export_max_o,
  output logic [63:0]      export_avg_o,
  output logic [31:0]      export_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import khmma_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StMod   = 9'b000000010,
    StScan  = 9'b000000100,
    StDec   = 9'b000001000,
    StRd    = 9'b000010000,
    StUpd   = 9'b000100000,
    StDiv   = 9'b001000000,
    StSweep = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  slot_t       mem [TableEntries];
  logic [TableEntries-1:0] used_q, used_d;
  logic [16:0] win_len_q;
  logic [31:0] ttl_q;
  logic [31:0] last_q, last_d;

  logic [63:0] item_q, host_q, val_q;
  logic        kind_q, pres_q;
  logic [31:0] ts_q;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  bit_q, bit_d;
  logic [31:0] now_q, now_d;

  logic [CntW-1:0] ptr_q, ptr_d;
  logic [IdxW-1:0] rd_idx;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_ptr_q;
  slot_t           rd_q;
  logic            used_rd_q;
  logic            found_q, found_d, free_q, free_d;
  logic [IdxW-1:0] hit_q, hit_d, fidx_q, fidx_d;

  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  slot_t       wr_dat;

  slot_t       exp_q, exp_d;
  logic        exv_q, exv_d;
  logic [1:0]  st_q, st_d;
  logic [63:0] avg_q, avg_d;
  logic        neg_q, neg_d;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot;

  khmma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (ddone),
    .quot_o (dquot)
  );

  logic [16:0] wlen;
  logic [32:0] rtry;
  slot_t       s;
  logic        lt_min, lt_max;
  logic [63:0] add;
  logic        ovf;
  logic [32:0] age;

  assign wlen = (win_len_q == '0) ? 17'd1 : win_len_q;
  assign busy = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !start;
  assign rd_idx = (state_q == StRd) ? hit_q : ptr_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_dat;
    end
    rd_q      <= mem[rd_idx];
    rd_ptr_q  <= rd_idx;
    used_rd_q <= used_q[rd_idx];
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    last_d  = last_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    now_d   = now_q;
    ptr_d   = ptr_q;
    found_d = found_q;
    free_d  = free_q;
    hit_d   = hit_q;
    fidx_d  = fidx_q;
    exp_d   = exp_q;
    exv_d   = exv_q;
    st_d    = st_q;
    avg_d   = avg_q;
    neg_d   = neg_q;
    wr_en   = 1'b0;
    wr_idx  = hit_q;
    wr_dat  = rd_q;
    dreq    = '{start: 1'b0, dividend: '0, divisor: '0};
    s       = rd_q;
    rtry    = {rem_q, ts_q[bit_q[4:0]]} - {16'd0, wlen};
    lt_min  = 1'b0;
    lt_max  = 1'b0;
    add     = '0;
    ovf     = 1'b0;
    age     = {1'b0, rd_q.win} + {1'b0, ttl_q};
    unique case (state_q)
      StIdle: begin
        if (start) begin
          exv_d = 1'b0;
          exp_d = '0;
          if (sample_type_i != TypeReal && sample_type_i != TypeUns) begin
            st_d    = StatusBadType;
            state_d = StOut;
          end else begin
            st_d    = StatusOk;
            rem_d   = '0;
            bit_d   = 6'd31;
            state_d = StMod;
          end
        end
      end
      StMod: begin
        if (!rtry[32]) begin
          rem_d = rtry[31:0];
        end else begin
          rem_d = {rem_q[30:0], ts_q[bit_q[4:0]]};
        end
        bit_d = bit_q - 6'd1;
        if (bit_q == 6'd0) begin
          now_d   = ts_q - rem_d;
          ptr_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (rd_vld_q) begin
          if (used_rd_q) begin
            if (!found_q && rd_q.item == item_q) begin
              found_d = 1'b1;
              hit_d   = rd_ptr_q;
            end
          end else if (!free_q) begin
            free_d = 1'b1;
            fidx_d = rd_ptr_q;
          end
        end
        if (ptr_q != CntW'(TableEntries)) begin
          ptr_d = ptr_q + CntW'(1);
        end
        if (rd_vld_q && rd_ptr_q == IdxW'(TableEntries - 1)) begin
          state_d = StDec;
        end
      end
      StDec: begin
        if (found_q) begin
          state_d = StRd;
        end else if (free_q) begin
          hit_d  = fidx_q;
          used_d[fidx_q] = 1'b1;
          wr_en  = 1'b1;
          wr_idx = fidx_q;
          wr_dat = '{item: item_q, host: host_q, kind: kind_q, win: now_q,
                     mn: '0, mx: '0, sum: '0, cnt: '0};
          state_d = StRd;
        end else begin
          st_d    = StatusFull;
          state_d = StSweep;
          ptr_d   = '0;
        end
      end
      StRd: begin
        state_d = StUpd;
      end
      StUpd: begin
        if (s.win != now_q || s.kind != kind_q) begin
          if (s.cnt != '0) begin
            exv_d = 1'b1;
            exp_d = s;
            neg_d = !s.kind && s.sum[63];
            dreq.start    = 1'b1;
            dreq.dividend = (!s.kind && s.sum[63]) ? (64'd0 - s.sum) : s.sum;
            dreq.divisor  = s.cnt;
          end
          s.kind = kind_q;
          s.win  = now_q;
          s.mn   = '0;
          s.mx   = '0;
          s.sum  = '0;
          s.cnt  = '0;
        end
        if (pres_q) begin
          lt_min = kind_q ? (val_q < s.mn) : ($signed(val_q) < $signed(s.mn));
          lt_max = kind_q ? (s.mx < val_q) : ($signed(s.mx) < $signed(val_q));
          if (s.cnt == '0 || lt_min) s.mn = val_q;
          if (s.cnt == '0 || lt_max) s.mx = val_q;
          add = s.sum + val_q;
          ovf = !kind_q && (s.sum[63] == val_q[63]) && (add[63] != s.sum[63]);
          if (ovf) begin
            s.sum = s.sum[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
          end else begin
            s.sum = add;
          end
          if (s.cnt != 32'hFFFFFFFF) s.cnt = s.cnt + 32'd1;
        end
        wr_en  = 1'b1;
        wr_dat = s;
        ptr_d  = '0;
        state_d = dreq.start ? StDiv : StSweep;
      end
      StDiv: begin
        if (ddone) begin
          avg_d   = neg_q ? (64'd0 - dquot) : dquot;
          state_d = StSweep;
        end
      end
      StSweep: begin
        if (last_q == now_q) begin
          state_d = StOut;
        end else begin
          if (rd_vld_q && ptr_q != '0) begin
            if (used_rd_q && age <= {1'b0, now_q}) begin
              used_d[rd_ptr_q] = 1'b0;
            end
          end
          if (ptr_q != CntW'(TableEntries)) begin
            ptr_d = ptr_q + CntW'(1);
          end
          if (rd_vld_q && ptr_q != '0 && rd_ptr_q == IdxW'(TableEntries - 1)) begin
            last_d  = now_q;
            state_d = StOut;
          end
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      used_q    <= '0;
      last_q    <= '0;
      win_len_q <= WindowReset;
      ttl_q     <= TtlReset;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      exv_q     <= 1'b0;
      st_q      <= StatusOk;
      bit_q     <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      last_q   <= last_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= (state_q == StScan || state_q == StSweep) &&
                  ptr_q != CntW'(TableEntries) && state_d == state_q;
      found_q  <= found_d;
      free_q   <= free_d;
      exv_q    <= exv_d;
      st_q     <= st_d;
      bit_q    <= bit_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegWindow: win_len_q <= cfg_data_i[16:0];
          RegTtl:    ttl_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      item_q <= item_id_i;
      host_q <= host_id_i;
      val_q  <= sample_value_i;
      kind_q <= sample_type_i[0];
      pres_q <= value_present_i;
      ts_q   <= timestamp_seconds_i;
    end
    rem_q  <= rem_d;
    now_q  <= now_d;
    hit_q  <= hit_d;
    fidx_q <= fidx_d;
    exp_q  <= exp_d;
    avg_q  <= avg_d;
    neg_q  <= neg_d;
  end

  assign done_o                = (state_q == StOut);
  assign status_o              = st_q;
  assign export_valid_o        = exv_q;
  assign export_item_id_o      = exv_q ? exp_q.item : '0;
  assign export_host_id_o      = exv_q ? exp_q.host : '0;
  assign export_type_o         = exv_q ? exp_q.kind : 1'b0;
  assign export_window_start_o = exv_q ? exp_q.win : '0;
  assign export_min_o          = exv_q ? exp_q.mn : '0;
  assign export_max_o          = exv_q ? exp_q.mx : '0;
  assign export_avg_o          = exv_q ? avg_q : '0;
  assign export_count_o        = exv_q ? exp_q.cnt : '0;
endmodule
`default_nettype wire

FILE: verif/khmma_checker.sv
// Checker for the keyed windowed min/max/average aggregator: watches the sample,
// result and register channels, predicts each result and compares it.
// Depends on khmma_pkg.
`timescale 1ns / 1ps
module khmma_checker import khmma_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [63:0] item_id_i,
  input  wire logic [63:0] host_id_i,
  input  wire logic [1:0]  sample_type_i,
  input  wire logic        value_present_i,
  input  wire logic [63:0] sample_value_i,
  input  wire logic [31:0] timestamp_seconds_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        export_valid_i,
  input  wire logic [63:0] export_item_id_i,
  input  wire logic [63:0] export_host_id_i,
  input  wire logic        export_type_i,
  input  wire logic [31:0] export_window_start_i,
  input  wire logic [63:0] export_min_i,
  input  wire logic [63:0] export_max_i,
  input  wire logic [63:0] export_avg_i,
  input  wire logic [31:0] export_count_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  typedef struct packed {
    logic [1:0]  status;
    logic        ev;
    logic [63:0] item;
    logic [63:0] host;
    logic        kind;
    logic [31:0] win;
    logic [63:0] mn;
    logic [63:0] mx;
    logic [63:0] avg;
    logic [31:0] cnt;
  } rec_t;

  bit          used[TableEntries];
  slot_t       slots[TableEntries];
  logic [31:0] sweep_win;
  logic [16:0] win_len;
  logic [31:0] ttl;
  rec_t        expected_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic bit lt(logic [63:0] a, logic [63:0] b, logic kind);
    return (kind == TypeReal[0]) ? ($signed(a) < $signed(b)) : (a < b);
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? 64'h8000_0000_0000_0000
                                                       : 64'h7FFF_FFFF_FFFF_FFFF;
    return r;
  endfunction

  function automatic logic [63:0] mean(logic [63:0] sum, logic [31:0] cnt, logic kind);
    logic [63:0] mag;
    if (kind == TypeUns[0] || !sum[63]) return sum / {32'd0, cnt};
    mag = (64'd0 - sum) / {32'd0, cnt};
    return 64'd0 - mag;
  endfunction

  function automatic void restart(int i, logic kind, logic [31:0] w);
    slots[i].kind = kind;
    slots[i].win  = w;
    slots[i].mn   = '0;
    slots[i].mx   = '0;
    slots[i].sum  = '0;
    slots[i].cnt  = '0;
  endfunction

  function automatic rec_t aggregate(logic [63:0] item, logic [63:0] host, logic [1:0] ty,
                                     logic pres, logic [63:0] val, logic [31:0] ts);
    rec_t        r;
    logic [31:0] wl;
    logic [31:0] now;
    int          hit;
    int          free_i;
    bit          found;
    bit          have_free;
    r = '0;
    hit = 0;
    free_i = 0;
    found = 0;
    have_free = 0;
    wl = (win_len == 0) ? 32'd1 : {15'd0, win_len};
    now = ts - ts % wl;
    if (ty != TypeReal && ty != TypeUns) begin
      r.status = StatusBadType;
      return r;
    end
    for (int i = 0; i < TableEntries; i++) begin
      if (used[i]) begin
        if (!found && slots[i].item == item) begin
          found = 1;
          hit = i;
        end
      end else if (!have_free) begin
        have_free = 1;
        free_i = i;
      end
    end
    if (!found && !have_free) begin
      r.status = StatusFull;
    end else begin
      r.status = StatusOk;
      if (!found) begin
        hit = free_i;
        used[hit] = 1;
        slots[hit].item = item;
        slots[hit].host = host;
        restart(hit, ty[0], now);
      end
      if (slots[hit].win != now || slots[hit].kind != ty[0]) begin
        if (slots[hit].cnt != 0) begin
          r.ev   = 1'b1;
          r.item = slots[hit].item;
          r.host = slots[hit].host;
          r.kind = slots[hit].kind;
          r.win  = slots[hit].win;
          r.mn   = slots[hit].mn;
          r.mx   = slots[hit].mx;
          r.avg  = mean(slots[hit].sum, slots[hit].cnt, slots[hit].kind);
          r.cnt  = slots[hit].cnt;
        end
        restart(hit, ty[0], now);
      end
      if (pres) begin
        if (slots[hit].cnt == 0 || lt(val, slots[hit].mn, ty[0])) slots[hit].mn = val;
        if (slots[hit].cnt == 0 || lt(slots[hit].mx, val, ty[0])) slots[hit].mx = val;
        slots[hit].sum = (ty == TypeReal) ? sat_add(slots[hit].sum, val)
                                          : slots[hit].sum + val;
        if (slots[hit].cnt != 32'hFFFF_FFFF) slots[hit].cnt++;
      end
    end
    if (sweep_win != now) begin
      sweep_win = now;
      for (int i = 0; i < TableEntries; i++) begin
        if (used[i] && ({1'b0, slots[i].win} + {1'b0, ttl}) <= {1'b0, now}) used[i] = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t got;
    rec_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < TableEntries; i++) used[i] = 0;
      sweep_win = '0;
      win_len = WindowReset;
      ttl = TtlReset;
      expected_q.delete();
      fails = 0;
    end else begin
      if (done_i) begin
        got = '{status_i, export_valid_i, export_item_id_i, export_host_id_i, export_type_i,
                export_window_start_i, export_min_i, export_max_i, export_avg_i,
                export_count_i};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: status %0d/%0d valid %0d/%0d item %h/%h host %h/%h",
                       exp_r.status, got.status, exp_r.ev, got.ev, exp_r.item, got.item,
                       exp_r.host, got.host);
              $display("  type %0d/%0d win %h/%h min %h/%h max %h/%h", exp_r.kind, got.kind,
                       exp_r.win, got.win, exp_r.mn, got.mn, exp_r.mx, got.mx);
              $display("  avg %h/%h count %0d/%0d", exp_r.avg, got.avg, exp_r.cnt, got.cnt);
            end
          end
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(aggregate(item_id_i, host_id_i, sample_type_i, value_present_i,
                                       sample_value_i, timestamp_seconds_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegWindow) win_len = cfg_data_i[16:0];
        else ttl = cfg_data_i;
      end
    end
  end
endmodule

FILE: verif/tb_top.sv
// Testbench top for keyed_hourly_min_max_avg: drives samples and register writes,
// gives the verdict. Depends on khmma_pkg, khmma_checker and the block.
`timescale 1ns / 1ps
module tb_top;
  import khmma_pkg::*;

  localparam longint CycleLimit = 12_000_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [63:0] item_id_i = '0;
  logic [63:0] host_id_i = '0;
  logic [1:0]  sample_type_i = '0;
  logic        value_present_i = 0;
  logic [63:0] sample_value_i = '0;
  logic [31:0] timestamp_seconds_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic        export_valid_o;
  logic [63:0] export_item_id_o;
  logic [63:0] export_host_id_o;
  logic        export_type_o;
  logic [31:0] export_window_start_o;
  logic [63:0] export_min_o;
  logic [63:0] export_max_o;
  logic [63:0] export_avg_o;
  logic [31:0] export_count_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  longint      cycles = 0;
  bit          gaps_on;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  keyed_hourly_min_max_avg dut (.*);

  khmma_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .item_id_i, .host_id_i,
    .sample_type_i, .value_present_i, .sample_value_i, .timestamp_seconds_i,
    .done_i(done_o), .status_i(status_o), .export_valid_i(export_valid_o),
    .export_item_id_i(export_item_id_o), .export_host_id_i(export_host_id_o),
    .export_type_i(export_type_o), .export_window_start_i(export_window_start_o),
    .export_min_i(export_min_o), .export_max_i(export_max_o), .export_avg_i(export_avg_o),
    .export_count_i(export_count_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("keyed_hourly_min_max_avg test failed");
      $finish;
    end
  end

  task automatic send_sample(logic [63:0] item, logic [63:0] host, logic [1:0] ty,
                             logic pres, logic [63:0] val, logic [31:0] ts);
    int gap;
    start <= 1'b1;
    item_id_i <= item;
    host_id_i <= host;
    sample_type_i <= ty;
    value_present_i <= pres;
    sample_value_i <= val;
    timestamp_seconds_i <= ts;
    do @(posedge clk_i); while (busy);
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    if (start) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return {{48{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(logic [16:0] wl, logic [31:0] life, int count);
    logic [63:0] keys[6];
    logic [63:0] hosts[6];
    logic [1:0]  kinds[6];
    logic [31:0] ts;
    logic [31:0] span;
    logic [63:0] key;
    logic [1:0]  ty;
    int          k;
    write_reg(RegWindow, {15'd0, wl});
    write_reg(RegTtl, life);
    gaps_on = $urandom_range(0, 3) != 0;
    span = (wl == 0) ? 32'd1 : {15'd0, wl};
    foreach (keys[i]) begin
      keys[i] = {$urandom, $urandom};
      hosts[i] = {$urandom, $urandom};
      kinds[i] = 2'($urandom_range(0, 1));
    end
    ts = $urandom;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 5);
      key = keys[k];
      ty = kinds[k];
      case ($urandom_range(0, 19))
        0: ts = $urandom;
        1: ts = ts - $urandom_range(0, 3) * span;
        2: key = {$urandom, $urandom};
        3: ty = 2'($urandom_range(2, 3));
        4: ty = ~ty & TypeUns;
        default: if ($urandom_range(0, 3) == 0) ts = ts + $urandom_range(0, 2 * span);
      endcase
      send_sample(key, ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : hosts[k], ty,
                  $urandom_range(0, 7) != 0, pick_value(), ts);
    end
  endtask

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    gaps_on = 1;
    a = 64'd1;
    b = '1;
    c = {$urandom, $urandom};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(a, 64'd7, TypeReal, 1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd100);
    send_sample(a, 64'd7, TypeReal, 1, 64'h7FFF_FFFF_FFFF_FFFF, 32'd200);
    send_sample(a, 64'd7, TypeReal, 1, 64'h8000_0000_0000_0000, 32'd300);
    send_sample(a, 64'd7, 2'd2, 1, 64'd5, 32'd300);
    send_sample(b, b, 2'd3, 1, b, b[31:0]);
    send_sample(a, 64'd7, TypeReal, 0, 64'd9, 32'd400);
    send_sample(a, 64'd7, TypeReal, 1, 64'hFFFF_FFFF_FFFF_FFFB, 32'd3700);
    send_sample(a, 64'd7, TypeReal, 1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd3800);
    send_sample(a, 64'd7, TypeUns, 1, '1, 32'd3800);
    send_sample(a, 64'd7, TypeUns, 1, '1, 32'd3900);
    send_sample(a, 64'd7, TypeUns, 1, 64'd0, 32'd3900);
    send_sample(b, b, TypeUns, 1, 64'd0, 32'd3700);
    send_sample(b, b, TypeUns, 0, b, 32'd3700);
    send_sample(a, 64'd7, TypeUns, 1, 64'd3, 32'd100);
    send_sample(c, ~c, TypeReal, 0, c, 32'd400_000);
    send_sample(c, ~c, TypeReal, 1, 64'h8000_0000_0000_0000, 32'd400_000);
    send_sample(c, ~c, TypeReal, 1, 64'h8000_0000_0000_0000, 32'd400_001);
    send_sample(c, ~c, TypeReal, 1, 64'd1, 32'd800_000);
    send_sample(b, 64'd0, TypeUns, 1, 64'd2, 32'hFFFF_FFFF);

    random_phase(17'd1, 32'd0, 90);
    random_phase(17'd0, 32'd5, 90);
    random_phase(17'd86400, 32'hFFFF_FFFF, 90);
    random_phase(17'h1FFFF, 32'd3, 90);
    random_phase(17'd7, 32'd20, 90);
    random_phase(17'd3600, 32'd172800, 90);

    if (start) start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2500) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("keyed_hourly_min_max_avg test passed");
    end else begin
      $display("keyed_hourly_min_max_avg test failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/khmma_pkg.sv
rtl/khmma_div.sv
rtl/keyed_hourly_min_max_avg.sv
verif/khmma_checker.sv
verif/tb_top.sv
